/* src/acfs_pkg.sv */
// Shared widths, codes, request structs and helpers for the ADC channel
// filter and statistics block. No dependencies.
package acfs_pkg;

  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned NUM_ALPHA    = 4;

  localparam int unsigned MV_W    = 12;
  localparam int unsigned FILT_W  = 20;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SUM_W   = 44;
  localparam int unsigned ALPHA_W = 16;
  localparam int unsigned CIDX_W  = 3;

  localparam logic [ALPHA_W-1:0] ONE_Q15   = 16'd32768;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd8192;
  localparam logic [3:0]         MASK_RST  = 4'hF;
  localparam logic [CNT_W-1:0]   CNT_MAX   = 32'hFFFF_FFFF;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_MASK   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_ALPHA0 = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ALPHA3 = 3'd4;

  // result status codes
  localparam logic [1:0] ST_QUEUED   = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_READ_ERR = 2'd2;
  localparam logic [1:0] ST_DISABLED = 2'd3;

  typedef struct packed {
    logic               start;
    logic [ALPHA_W-1:0] alpha;
    logic [FILT_W-1:0]  x;
    logic [FILT_W-1:0]  f;
  } ema_req_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

/* src/acfs_ema.sv */
// Exponential average update on one shared multiplier, two products in turn.
// Depends on acfs_pkg.
module acfs_ema (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  acfs_pkg::ema_req_t        req_i,
  output logic                      done_o,
  output logic [acfs_pkg::FILT_W-1:0] result_o
);

  localparam int unsigned ACC_W = acfs_pkg::ALPHA_W + acfs_pkg::FILT_W;
  localparam logic [ACC_W-1:0] ROUND = ACC_W'(16384);

  logic                           busy_q, phase_q, done_q;
  logic [acfs_pkg::ALPHA_W-1:0]   a_q, w_q;
  logic [acfs_pkg::FILT_W-1:0]    x_q, f_q;
  logic [ACC_W-1:0]               acc_q;
  logic [acfs_pkg::ALPHA_W-1:0]   a_clamp;
  logic [acfs_pkg::ALPHA_W-1:0]   mul_a;
  logic [acfs_pkg::FILT_W-1:0]    mul_b;
  logic [ACC_W-1:0]               prod;

  // clamp weight to one
  assign a_clamp = (req_i.alpha > acfs_pkg::ONE_Q15) ? acfs_pkg::ONE_Q15 : req_i.alpha;

  // shared multiplier: new sample first, then old state
  assign mul_a = phase_q ? w_q : a_q;
  assign mul_b = phase_q ? f_q : x_q;
  assign prod  = ACC_W'(mul_a) * ACC_W'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
      end else if (busy_q) begin
        phase_q <= ~phase_q;
        if (phase_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= a_clamp;
      w_q   <= acfs_pkg::ONE_Q15 - a_clamp;
      x_q   <= req_i.x;
      f_q   <= req_i.f;
      acc_q <= ROUND;
    end else if (busy_q) begin
      acc_q <= acc_q + prod;
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q[acfs_pkg::FILT_W+14:15];

endmodule

/* src/acfs_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on acfs_pkg.
module acfs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  acfs_pkg::div_req_t         req_i,
  output logic                       done_o,
  output logic [acfs_pkg::SUM_W-1:0] quot_o
);

  localparam int unsigned SW  = acfs_pkg::SUM_W;
  localparam int unsigned CW  = acfs_pkg::CNT_W;
  localparam int unsigned STW = $clog2(SW);
  localparam logic [STW-1:0] LAST = STW'(SW - 1);

  logic           busy_q, done_q;
  logic [STW-1:0] step_q;
  logic [SW-1:0]  dvd_q;
  logic [CW-1:0]  dvs_q, rem_q;
  logic [CW:0]    rem_sh;
  logic           fits;

  // shift in next dividend bit, compare and subtract
  assign rem_sh = {rem_q, dvd_q[SW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? CW'(rem_sh - {1'b0, dvs_q}) : rem_sh[CW-1:0];
      dvd_q <= {dvd_q[SW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

/* src/adc_channel_filter_stats_top.sv */
// Flow: a primed good read passes decode, filter, statistics and mean to the output; a
// first sample skips the filter, a read error skips it and the statistics, and a disabled
// channel goes straight to the output; the 44-step divider dominates. One item at a time: the
// input is ready once the result sits in the output register, so a waiting result does not block it.
// Reset: asynchronous, clears all channel state and restores register defaults.
// Depends on acfs_pkg, acfs_ema and acfs_div.
module adc_channel_filter_stats_top #(
  parameter int unsigned CHANNELS = acfs_pkg::CHANNELS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [1:0] channel, [2] raw_read_ok, [3] volt_read_ok, [15:4] raw_code,
  // [27:16] sample_mv, [28] queue_accepted, [31:29] zero
  input  logic [31:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [1:0] status, [3:2] channel_out, [15:4] raw_out, [27:16] voltage_out,
  // [47:28] filtered_out, [79:48] sequence_out, [91:80] min_mv, [103:92] max_mv,
  // [115:104] mean_mv, [147:116] accepted_count, [179:148] dropped_count,
  // [211:180] error_total, [215:212] zero
  output logic [215:0] m_axis_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [acfs_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [acfs_pkg::ALPHA_W-1:0] cfg_data_i
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MW = acfs_pkg::MV_W;
  localparam int unsigned FW = acfs_pkg::FILT_W;
  localparam int unsigned NW = acfs_pkg::CNT_W;
  localparam int unsigned SW = acfs_pkg::SUM_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_FILT, S_STAT, S_MEAN, S_DIV, S_OUT
  } state_e;

  // configuration registers
  logic [3:0]                   en_mask_q;
  logic [acfs_pkg::ALPHA_W-1:0] alpha_q [acfs_pkg::NUM_ALPHA];
  logic [acfs_pkg::CIDX_W-1:0]  alpha_idx;

  assign cfg_ready_o = 1'b1;
  assign alpha_idx   = cfg_index_i - acfs_pkg::REG_ALPHA0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_mask_q <= acfs_pkg::MASK_RST;
      for (int i = 0; i < acfs_pkg::NUM_ALPHA; i++) alpha_q[i] <= acfs_pkg::ALPHA_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == acfs_pkg::REG_MASK) begin
        en_mask_q <= cfg_data_i[3:0];
      end else if (cfg_index_i >= acfs_pkg::REG_ALPHA0 &&
                   cfg_index_i <= acfs_pkg::REG_ALPHA3) begin
        alpha_q[alpha_idx[1:0]] <= cfg_data_i;
      end
    end
  end

  // item fields
  logic [1:0]    ch_q;
  logic          raw_ok_q, volt_ok_q, qacc_q;
  logic [MW-1:0] raw_q, mv_q;

  // per-channel state
  logic [FW-1:0] filt_q    [CHANNELS];
  logic          primed_q  [CHANNELS];
  logic [NW-1:0] seq_q     [CHANNELS];
  logic [NW-1:0] acc_tot_q [CHANNELS];
  logic [NW-1:0] drop_q    [CHANNELS];
  logic [NW-1:0] err_q     [CHANNELS];
  logic [MW-1:0] min_q     [CHANNELS];
  logic [MW-1:0] max_q     [CHANNELS];
  logic [SW-1:0] sum_q     [CHANNELS];

  // sequencer and result registers
  state_e         state_q;
  logic [1:0]     status_q;
  logic [NW-1:0]  seq_out_q;
  logic [MW-1:0]  mean_q;
  logic           m_tvalid_q;
  logic [215:0]   m_tdata_q;

  logic [CW-1:0]  ci;
  logic           enabled, read_ok, first;
  logic [FW-1:0]  x_val;
  logic           in_xfer, out_free;

  acfs_pkg::ema_req_t         ema_req;
  logic                       ema_done;
  logic [FW-1:0]              ema_res;
  acfs_pkg::div_req_t         div_req;
  logic                       div_done;
  logic [SW-1:0]              div_quot;

  assign ci      = ch_q[CW-1:0];
  assign enabled = (32'(ch_q) < CHANNELS) && en_mask_q[ch_q];
  assign read_ok = raw_ok_q && volt_ok_q;
  assign first   = acc_tot_q[ci] == '0;
  assign x_val   = {mv_q, 8'b0};

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_tvalid_q || m_axis_tready_i;

  // filter request for a primed channel
  assign ema_req.start = (state_q == S_DEC) && enabled && read_ok && primed_q[ci];
  assign ema_req.alpha = alpha_q[ch_q];
  assign ema_req.x     = x_val;
  assign ema_req.f     = filt_q[ci];

  // mean request after the statistics settle
  assign div_req.start    = (state_q == S_MEAN);
  assign div_req.dividend = sum_q[ci];
  assign div_req.divisor  = acc_tot_q[ci];

  acfs_ema u_ema (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (ema_req),
    .done_o   (ema_done),
    .result_o (ema_res)
  );

  acfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // assemble the result word
  logic [215:0] res_word;
  always_comb begin
    res_word        = '0;
    res_word[1:0]   = status_q;
    res_word[3:2]   = ch_q;
    if (status_q != acfs_pkg::ST_DISABLED) begin
      res_word[91:80]   = min_q[ci];
      res_word[103:92]  = max_q[ci];
      res_word[115:104] = mean_q;
      res_word[147:116] = acc_tot_q[ci];
      res_word[179:148] = drop_q[ci];
      res_word[211:180] = err_q[ci];
      if (status_q != acfs_pkg::ST_READ_ERR) begin
        res_word[15:4]  = raw_q;
        res_word[27:16] = mv_q;
        res_word[47:28] = filt_q[ci];
        res_word[79:48] = seq_out_q;
      end
    end
  end

  // hold the item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ch_q      <= s_axis_tdata_i[1:0];
      raw_ok_q  <= s_axis_tdata_i[2];
      volt_ok_q <= s_axis_tdata_i[3];
      raw_q     <= s_axis_tdata_i[15:4];
      mv_q      <= s_axis_tdata_i[27:16];
      qacc_q    <= s_axis_tdata_i[28];
    end
  end

  // sequencer, channel state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      status_q   <= acfs_pkg::ST_QUEUED;
      seq_out_q  <= '0;
      mean_q     <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        filt_q[i]    <= '0;
        primed_q[i]  <= 1'b0;
        seq_q[i]     <= '0;
        acc_tot_q[i] <= '0;
        drop_q[i]    <= '0;
        err_q[i]     <= '0;
        min_q[i]     <= '0;
        max_q[i]     <= '0;
        sum_q[i]     <= '0;
      end
    end else begin
      if (m_tvalid_q && m_axis_tready_i && state_q != S_OUT) m_tvalid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_xfer) state_q <= S_DEC;
        end
        S_DEC: begin
          if (!enabled) begin
            status_q <= acfs_pkg::ST_DISABLED;
            state_q  <= S_OUT;
          end else if (!read_ok) begin
            status_q  <= acfs_pkg::ST_READ_ERR;
            err_q[ci] <= acfs_pkg::sat_inc(err_q[ci]);
            state_q   <= S_MEAN;
          end else if (primed_q[ci]) begin
            state_q <= S_FILT;
          end else begin
            filt_q[ci]   <= x_val;
            primed_q[ci] <= 1'b1;
            state_q      <= S_STAT;
          end
        end
        S_FILT: begin
          if (ema_done) begin
            filt_q[ci] <= ema_res;
            state_q    <= S_STAT;
          end
        end
        S_STAT: begin
          seq_out_q <= seq_q[ci];
          seq_q[ci] <= seq_q[ci] + 1'b1;
          if (qacc_q) begin
            status_q <= acfs_pkg::ST_QUEUED;
            if (first || mv_q < min_q[ci]) min_q[ci] <= mv_q;
            if (first || mv_q > max_q[ci]) max_q[ci] <= mv_q;
            if (acc_tot_q[ci] != acfs_pkg::CNT_MAX) begin
              acc_tot_q[ci] <= acc_tot_q[ci] + 1'b1;
              sum_q[ci]     <= sum_q[ci] + SW'(mv_q);
            end
          end else begin
            status_q   <= acfs_pkg::ST_DROPPED;
            drop_q[ci] <= acfs_pkg::sat_inc(drop_q[ci]);
          end
          state_q <= S_MEAN;
        end
        S_MEAN: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            mean_q  <= first ? '0 : div_quot[MW-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= res_word;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  // an accepted item always moves to decode
  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_DEC)
    else $error("accepted item did not enter decode");

  // filter results arrive only while the sequencer waits for them
  a_ema_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ema_done |-> state_q == S_FILT)
    else $error("filter done outside filter wait");

  // divider results arrive only while the sequencer waits for them
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside divide wait");

  // a finished result loads the output register and frees the input
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (m_tvalid_q && state_q == S_IDLE))
    else $error("result not loaded into output register");

endmodule

/* bench/adc_channel_filter_stats_top_tb.sv */
// Self-checking bench for adc_channel_filter_stats_top: a per-channel filter and
// statistics predictor checks every result, under random idling and stalls.
// Depends on acfs_pkg and the RTL of adc_channel_filter_stats_top.
module adc_channel_filter_stats_top_tb;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS  = 230;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  // one sample attempt, laid out as s_axis_tdata_i
  typedef struct packed {
    logic [2:0]                pad;
    logic                      queue_accepted;
    logic [acfs_pkg::MV_W-1:0] sample_mv;
    logic [acfs_pkg::MV_W-1:0] raw_code;
    logic                      volt_ok;
    logic                      raw_ok;
    logic [1:0]                channel;
  } sample_t;

  // one channel report, laid out as m_axis_tdata_o
  typedef struct packed {
    logic [3:0]                  pad;
    logic [acfs_pkg::CNT_W-1:0]  err_total;
    logic [acfs_pkg::CNT_W-1:0]  drop_total;
    logic [acfs_pkg::CNT_W-1:0]  acc_total;
    logic [acfs_pkg::MV_W-1:0]   mean_mv;
    logic [acfs_pkg::MV_W-1:0]   max_mv;
    logic [acfs_pkg::MV_W-1:0]   min_mv;
    logic [acfs_pkg::CNT_W-1:0]  seq_no;
    logic [acfs_pkg::FILT_W-1:0] filtered;
    logic [acfs_pkg::MV_W-1:0]   voltage;
    logic [acfs_pkg::MV_W-1:0]   raw;
    logic [1:0]                  channel;
    logic [1:0]                  status;
  } report_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [31:0]                   s_axis_tdata_i = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [215:0]                  m_axis_tdata_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [acfs_pkg::CIDX_W-1:0]   cfg_index_i = '0;
  logic [acfs_pkg::ALPHA_W-1:0]  cfg_data_i = '0;

  // predictor copy of registers and channel state
  logic [3:0]                    en_mask;
  logic [acfs_pkg::ALPHA_W-1:0]  alpha_w    [acfs_pkg::CHANNELS_DEF];
  logic [acfs_pkg::FILT_W-1:0]   ema_state  [acfs_pkg::CHANNELS_DEF];
  logic                          ema_loaded [acfs_pkg::CHANNELS_DEF];
  logic [acfs_pkg::CNT_W-1:0]    pkt_seq    [acfs_pkg::CHANNELS_DEF];
  logic [acfs_pkg::CNT_W-1:0]    acc_cnt    [acfs_pkg::CHANNELS_DEF];
  logic [acfs_pkg::CNT_W-1:0]    drop_cnt   [acfs_pkg::CHANNELS_DEF];
  logic [acfs_pkg::CNT_W-1:0]    err_cnt    [acfs_pkg::CHANNELS_DEF];
  logic [acfs_pkg::MV_W-1:0]     lo_mv      [acfs_pkg::CHANNELS_DEF];
  logic [acfs_pkg::MV_W-1:0]     hi_mv      [acfs_pkg::CHANNELS_DEF];
  logic [acfs_pkg::SUM_W-1:0]    mv_sum     [acfs_pkg::CHANNELS_DEF];

  sample_t             pending_samples[$];
  report_t             expected_reports[$];
  sample_t             cur_sample;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         mismatch_count = 0;

  adc_channel_filter_stats_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Apply one accepted sample to the channel state and build its report.
  function automatic report_t advance_channel_stats(input sample_t s);
    report_t     r;
    int          c;
    logic        first;
    logic [63:0] wa;
    logic [63:0] wx;
    logic [63:0] wf;
    logic [63:0] blend;
    r = '0;
    c = s.channel;
    r.channel = s.channel;
    if (c >= acfs_pkg::CHANNELS_DEF || !en_mask[c]) begin
      r.status = acfs_pkg::ST_DISABLED;
      return r;
    end
    if (!s.raw_ok || !s.volt_ok) begin
      if (err_cnt[c] != acfs_pkg::CNT_MAX) err_cnt[c] = err_cnt[c] + 1;
      r.status = acfs_pkg::ST_READ_ERR;
    end else begin
      wx = {44'd0, s.sample_mv, 8'd0};
      if (ema_loaded[c]) begin
        // clamp alpha to one, then blend with round half up
        wa = (alpha_w[c] > acfs_pkg::ONE_Q15) ? 64'(acfs_pkg::ONE_Q15) : 64'(alpha_w[c]);
        wf = 64'(ema_state[c]);
        blend = wa * wx + (64'd32768 - wa) * wf + 64'd16384;
        ema_state[c] = blend[34:15];
      end else begin
        ema_state[c] = wx[acfs_pkg::FILT_W-1:0];
        ema_loaded[c] = 1'b1;
      end
      r.raw = s.raw_code;
      r.voltage = s.sample_mv;
      r.filtered = ema_state[c];
      r.seq_no = pkt_seq[c];
      pkt_seq[c] = pkt_seq[c] + 1;
      if (s.queue_accepted) begin
        first = (acc_cnt[c] == 0);
        if (first || s.sample_mv < lo_mv[c]) lo_mv[c] = s.sample_mv;
        if (first || s.sample_mv > hi_mv[c]) hi_mv[c] = s.sample_mv;
        // freeze the sum once the count saturates
        if (acc_cnt[c] != acfs_pkg::CNT_MAX) begin
          acc_cnt[c] = acc_cnt[c] + 1;
          mv_sum[c] = mv_sum[c] + s.sample_mv;
        end
        r.status = acfs_pkg::ST_QUEUED;
      end else begin
        if (drop_cnt[c] != acfs_pkg::CNT_MAX) drop_cnt[c] = drop_cnt[c] + 1;
        r.status = acfs_pkg::ST_DROPPED;
      end
    end
    r.min_mv = lo_mv[c];
    r.max_mv = hi_mv[c];
    r.mean_mv = (acc_cnt[c] == 0) ? '0 : acfs_pkg::MV_W'(mv_sum[c] / acc_cnt[c]);
    r.acc_total = acc_cnt[c];
    r.drop_total = drop_cnt[c];
    r.err_total = err_cnt[c];
    return r;
  endfunction

  function automatic string fmt_report(input report_t r);
    return $sformatf({"st=%0d ch=%0d raw=%0d mv=%0d filt=%0h seq=%0d min=%0d max=%0d",
                      " mean=%0d acc=%0d drop=%0d err=%0d pad=%0h"},
                     r.status, r.channel, r.raw, r.voltage, r.filtered, r.seq_no,
                     r.min_mv, r.max_mv, r.mean_mv, r.acc_total, r.drop_total,
                     r.err_total, r.pad);
  endfunction

  function automatic sample_t mk_sample(input int ch, input bit rok, input bit vok,
                                        input int raw, input int mv, input bit qa);
    sample_t s;
    s = '0;
    s.channel = ch[1:0];
    s.raw_ok = rok;
    s.volt_ok = vok;
    s.raw_code = raw[acfs_pkg::MV_W-1:0];
    s.sample_mv = mv[acfs_pkg::MV_W-1:0];
    s.queue_accepted = qa;
    return s;
  endfunction

  // Mostly good reads with random content; some read errors and full-queue drops.
  function automatic sample_t rand_sample();
    sample_t     s;
    int unsigned kind;
    int unsigned pick;
    s = '0;
    s.channel = 2'($urandom_range(0, 3));
    s.raw_code = acfs_pkg::MV_W'($urandom_range(0, 4095));
    kind = $urandom_range(0, 99);
    s.raw_ok = !(kind < 8 || (kind >= 16 && kind < 20));
    s.volt_ok = !(kind >= 8 && kind < 20);
    s.queue_accepted = ($urandom_range(0, 99) < 70);
    pick = $urandom_range(0, 19);
    if (pick == 0) s.sample_mv = '0;
    else if (pick == 1) s.sample_mv = '1;
    else s.sample_mv = acfs_pkg::MV_W'($urandom_range(0, 4095));
    return s;
  endfunction

  // Present pending samples; predict each one on its input transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_reports.push_back(advance_channel_stats(cur_sample));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_sample = pending_samples.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= cur_sample;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Stall the result side at random.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check each result transfer against the oldest expected report.
  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: %s", fmt_report(got));
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result mismatch");
            $display("  expected %s", fmt_report(want));
            $display("  actual   %s", fmt_report(got));
          end
        end
      end
    end
  end

  // Wait until every sample has been sent and every report has come back.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid_i || expected_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Call at a rising edge; returns at the edge of the transfer.
  task automatic cfg_write(input logic [acfs_pkg::CIDX_W-1:0] idx,
                           input logic [acfs_pkg::ALPHA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == acfs_pkg::REG_MASK) en_mask = val[3:0];
    else alpha_w[2'(idx - acfs_pkg::REG_ALPHA0)] = val;
  endtask

  task automatic load_settings(input logic [3:0] mask,
                               input logic [acfs_pkg::ALPHA_W-1:0] a0,
                               input logic [acfs_pkg::ALPHA_W-1:0] a1,
                               input logic [acfs_pkg::ALPHA_W-1:0] a2,
                               input logic [acfs_pkg::ALPHA_W-1:0] a3);
    @(posedge clk_i);
    cfg_write(acfs_pkg::REG_MASK, acfs_pkg::ALPHA_W'(mask));
    cfg_write(acfs_pkg::REG_ALPHA0, a0);
    cfg_write(acfs_pkg::REG_ALPHA0 + 3'd1, a1);
    cfg_write(acfs_pkg::REG_ALPHA0 + 3'd2, a2);
    cfg_write(acfs_pkg::REG_ALPHA3, a3);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [acfs_pkg::ALPHA_W-1:0] rand_alpha();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return acfs_pkg::ONE_Q15;
      2: return acfs_pkg::ALPHA_W'($urandom_range(32769, 65535));
      default: return acfs_pkg::ALPHA_W'($urandom_range(1, 32767));
    endcase
  endfunction

  initial begin
    int unsigned ph;
    sample_t     s;
    en_mask = acfs_pkg::MASK_RST;
    for (int c = 0; c < acfs_pkg::CHANNELS_DEF; c++) begin
      alpha_w[c] = acfs_pkg::ALPHA_RST;
      ema_state[c] = '0;
      ema_loaded[c] = 1'b0;
      pkt_seq[c] = '0;
      acc_cnt[c] = '0;
      drop_cnt[c] = '0;
      err_cnt[c] = '0;
      lo_mv[c] = '0;
      hi_mv[c] = '0;
      mv_sum[c] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, default registers: first sample loads the filter, first accepted
    // sample loads min and max, read errors on either conversion, full queue.
    pending_samples.push_back(mk_sample(0, 1, 1, 4095, 4095, 1));
    pending_samples.push_back(mk_sample(0, 1, 1, 0, 0, 1));
    pending_samples.push_back(mk_sample(0, 0, 1, 1234, 999, 1));
    pending_samples.push_back(mk_sample(0, 1, 0, 1234, 999, 0));
    pending_samples.push_back(mk_sample(1, 1, 1, 2048, 0, 0));
    pending_samples.push_back(mk_sample(1, 1, 1, 2047, 2000, 1));
    pending_samples.push_back(mk_sample(1, 1, 1, 1, 4095, 1));
    pending_samples.push_back(mk_sample(2, 1, 1, 4095, 4095, 0));
    pending_samples.push_back(mk_sample(2, 1, 1, 0, 1, 1));
    pending_samples.push_back(mk_sample(3, 0, 0, 4095, 4095, 1));
    pending_samples.push_back(mk_sample(3, 1, 1, 2730, 1365, 1));
    drain();

    // Every channel disabled.
    load_settings(4'h0, acfs_pkg::ALPHA_RST, acfs_pkg::ALPHA_RST, acfs_pkg::ALPHA_RST,
                  acfs_pkg::ALPHA_RST);
    pending_samples.push_back(mk_sample(0, 1, 1, 100, 100, 1));
    pending_samples.push_back(mk_sample(3, 0, 1, 4095, 4095, 0));
    drain();

    // Alpha extremes: one, above one, zero, just above one.
    load_settings(4'hF, acfs_pkg::ONE_Q15, 16'hFFFF, 16'd0, 16'd32769);
    for (int c = 0; c < acfs_pkg::CHANNELS_DEF; c++) begin
      pending_samples.push_back(mk_sample(c, 1, 1, 3000, 3000, 1));
      pending_samples.push_back(mk_sample(c, 1, 1, 17, 17, 0));
    end
    drain();

    // Random phases, each with new settings and an idling pattern.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      load_settings((ph == 0) ? 4'hF : 4'($urandom_range(1, 15)),
                    rand_alpha(), rand_alpha(), rand_alpha(), rand_alpha());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        s = rand_sample();
        pending_samples.push_back(s);
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("adc_channel_filter_stats_top_tb OK");
    end else begin
      $display("adc_channel_filter_stats_top_tb NOT OK");
    end
    $finish;
  end

  // Give up on a hung run.
  initial begin
    #(20_000_000);
    $display("adc_channel_filter_stats_top_tb NOT OK");
    $finish;
  end

endmodule
